### hdl/media_clock_anchor_sync_macros.svh
// ----------------------------------------------------------------------------
// media_clock_anchor_sync_macros
// Assertion macros shared by the media clock anchor sync RTL.
// ----------------------------------------------------------------------------
`ifndef MEDIA_CLOCK_ANCHOR_SYNC_MACROS_SVH
`define MEDIA_CLOCK_ANCHOR_SYNC_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked out of reset.
`define MCAS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("media_clock_anchor_sync assertion failed");

// Next-cycle implication, checked out of reset.
`define MCAS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("media_clock_anchor_sync assertion failed");

`else

`define MCAS_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define MCAS_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

### hdl/mcas_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcas_pkg
// Types, codes and widths for the media clock anchor sync block.
// ----------------------------------------------------------------------------
package mcas_pkg;

    localparam int TIME_W    = 48;
    localparam int RATE_W    = 24;
    localparam int RATE_FRAC = 16;
    localparam int PROD_W    = TIME_W + RATE_W;
    localparam int ACT_W     = 3;
    localparam int CFG_IDX_W = 1;

    localparam logic signed [TIME_W-1:0] TIME_MAX  = {1'b0, {(TIME_W-1){1'b1}}};
    localparam logic signed [TIME_W-1:0] TIME_NONE = {TIME_W{1'b1}};   // -1 sentinel

    localparam logic [RATE_W-1:0] RATE_RESET = RATE_W'(1) << RATE_FRAC;  // 1.0

    typedef enum logic [ACT_W-1:0] {
        ACT_UPDATE = 3'd0,
        ACT_PAUSE  = 3'd1,
        ACT_RESUME = 3'd2,
        ACT_QUERY  = 3'd3,
        ACT_CLEAR  = 3'd4
    } action_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PLAYBACK_RATE = 1'b0,
        REG_CLOCK_MODE    = 1'b1
    } cfg_index_t;

    typedef struct packed {
        logic        [ACT_W-1:0]  action;
        logic        [TIME_W-1:0] now_us;
        logic signed [TIME_W-1:0] media_pts;
        logic        [TIME_W-1:0] anchor_sys_time;
        logic signed [TIME_W-1:0] max_media_time;
    } in_word_t;

    typedef struct packed {
        logic signed [TIME_W-1:0] media_clock;
        logic                     is_paused;
        logic                     is_anchored;
    } out_word_t;

endpackage

### hdl/media_clock_anchor_sync.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// media_clock_anchor_sync
// Master media clock: anchor pair, running maximum and pause state, one
// result word per action word.
// ----------------------------------------------------------------------------
//
//  channel  | dir | handshake          | payload
//  ---------+-----+--------------------+-------------------------------------
//  s_       | in  | s_valid / s_ready  | mcas_pkg::in_word_t  (action word)
//  m_       | out | m_valid / m_ready  | mcas_pkg::out_word_t (clock result)
//  cfg_     | in  | cfg_wr_en          | cfg_index, cfg_wdata (rate, mode)
//
//  Throughput is one word per clock while m_ready is high; an accepted word
//  loads the input register and then the result register, and m_valid rises
//  when the result register loads.
//  The critical path is the anchor select, the elapsed-time subtract, the
//  48x24 rate multiply and the saturating add and cap, all combinational.
//  Reset (aresetn low, synchronous) clears all anchor/pause state, both
//  pipeline valid bits, and loads rate 1.0 and audio mode.
//  A stall on m_ready holds the result register; the input register takes
//  a word while it is empty or its word can move into the result register.
//
`include "media_clock_anchor_sync_macros.svh"

module media_clock_anchor_sync (
    input  logic                                aclk,
    input  logic                                aresetn,

    input  logic                                s_valid,
    output logic                                s_ready,
    input  mcas_pkg::in_word_t                  s_data,

    output logic                                m_valid,
    input  logic                                m_ready,
    output mcas_pkg::out_word_t                 m_data,

    input  logic                                cfg_wr_en,
    input  logic [mcas_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [mcas_pkg::RATE_W-1:0]         cfg_wdata
);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [mcas_pkg::RATE_W-1:0] rate_reg;
    logic                        mode_reg;     // 0 audio, 1 system

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rate_reg <= mcas_pkg::RATE_RESET;
            mode_reg <= 1'b0;
        end else if (cfg_wr_en) begin
            unique case (mcas_pkg::cfg_index_t'(cfg_index))
                mcas_pkg::REG_PLAYBACK_RATE: rate_reg <= cfg_wdata;
                mcas_pkg::REG_CLOCK_MODE:    mode_reg <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Pipeline control: input register feeds the result register
    // ------------------------------------------------------------------
    logic                  in_valid_reg;
    mcas_pkg::in_word_t    in_reg;
    logic                  out_valid_reg;
    mcas_pkg::out_word_t   out_reg;
    logic                  advance;

    // Move the held word forward when the result slot is free or draining.
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_reg <= s_data;
        end
    end

    // ------------------------------------------------------------------
    // Clock state
    // ------------------------------------------------------------------
    logic signed [mcas_pkg::TIME_W-1:0] anchor_media_reg, anchor_media_next;
    logic        [mcas_pkg::TIME_W-1:0] anchor_sys_reg,   anchor_sys_next;
    logic signed [mcas_pkg::TIME_W-1:0] max_media_reg,    max_media_next;
    logic                               anchored_reg,     anchored_next;
    logic                               paused_reg,       paused_next;
    logic        [mcas_pkg::TIME_W-1:0] pause_sys_reg,    pause_sys_next;
    logic signed [mcas_pkg::TIME_W-1:0] pause_media_reg,  pause_media_next;

    mcas_pkg::action_t                  act;
    logic signed [mcas_pkg::TIME_W-1:0] upd_max;

    assign act = mcas_pkg::action_t'(in_reg.action);

    // Running maximum for an anchor update: new pts, old max once anchored,
    // and the candidate unless it carries the "none" sentinel.
    always_comb begin
        upd_max = in_reg.media_pts;
        if (anchored_reg && (max_media_reg > upd_max)) begin
            upd_max = max_media_reg;
        end
        if ((in_reg.max_media_time != mcas_pkg::TIME_NONE)
            && (in_reg.max_media_time > upd_max)) begin
            upd_max = in_reg.max_media_time;
        end
    end

    // Anchor, maximum and flags after the action. The pause snapshot is
    // handled below since it needs the scaled clock.
    always_comb begin
        anchor_media_next = anchor_media_reg;
        anchor_sys_next   = anchor_sys_reg;
        max_media_next    = max_media_reg;
        anchored_next     = anchored_reg;
        paused_next       = paused_reg;
        unique case (act)
            mcas_pkg::ACT_UPDATE: begin
                anchor_media_next = in_reg.media_pts;
                anchor_sys_next   = in_reg.anchor_sys_time;
                max_media_next    = upd_max;
                anchored_next     = 1'b1;
            end
            mcas_pkg::ACT_PAUSE: begin
                paused_next = 1'b1;
            end
            mcas_pkg::ACT_RESUME: begin
                if (paused_reg) begin
                    anchor_sys_next   = in_reg.now_us;
                    anchor_media_next = pause_media_reg;
                    paused_next       = 1'b0;
                end
            end
            mcas_pkg::ACT_CLEAR: begin
                anchor_media_next = '0;
                anchor_sys_next   = '0;
                max_media_next    = '0;
                anchored_next     = 1'b0;
                paused_next       = 1'b0;
            end
            default: ;  // query and unused codes: no state change
        endcase
    end

    // ------------------------------------------------------------------
    // Scaled clock from the post-action anchor at now_us
    // ------------------------------------------------------------------
    logic        [mcas_pkg::TIME_W-1:0] delta;
    logic        [mcas_pkg::PROD_W-1:0] prod;
    logic signed [mcas_pkg::TIME_W-1:0] scaled;
    logic signed [mcas_pkg::TIME_W:0]   clk_sum;
    logic signed [mcas_pkg::TIME_W-1:0] clk_at;

    // Floor elapsed time at zero when system time is behind the anchor.
    assign delta = (in_reg.now_us > anchor_sys_next) ? (in_reg.now_us - anchor_sys_next)
                                                     : '0;

    assign prod = {{mcas_pkg::RATE_W{1'b0}}, delta}
                * {{mcas_pkg::TIME_W{1'b0}}, rate_reg};

    // Saturate the Q56.16 product of the Q8.16 rate to the largest positive time.
    assign scaled = (prod[mcas_pkg::PROD_W-1 : mcas_pkg::RATE_FRAC+mcas_pkg::TIME_W-1] != '0)
                  ? mcas_pkg::TIME_MAX
                  : prod[mcas_pkg::RATE_FRAC +: mcas_pkg::TIME_W];

    assign clk_sum = {anchor_media_next[mcas_pkg::TIME_W-1], anchor_media_next}
                   + {1'b0, scaled};

    // Only positive overflow can occur since scaled is never negative.
    assign clk_at = (!clk_sum[mcas_pkg::TIME_W] && clk_sum[mcas_pkg::TIME_W-1])
                  ? mcas_pkg::TIME_MAX
                  : clk_sum[mcas_pkg::TIME_W-1:0];

    // ------------------------------------------------------------------
    // Pause snapshot and result
    // ------------------------------------------------------------------
    mcas_pkg::out_word_t result;

    always_comb begin
        pause_sys_next   = pause_sys_reg;
        pause_media_next = pause_media_reg;
        unique case (act)
            mcas_pkg::ACT_UPDATE: begin
                if (paused_reg) begin
                    pause_media_next = in_reg.media_pts;
                    pause_sys_next   = in_reg.anchor_sys_time;
                end
            end
            mcas_pkg::ACT_PAUSE: begin
                // Anchor is unchanged by pause, so clk_at is the pre-pause clock.
                if (!paused_reg) begin
                    pause_sys_next   = in_reg.now_us;
                    pause_media_next = clk_at;
                end
            end
            mcas_pkg::ACT_CLEAR: begin
                pause_sys_next   = '0;
                pause_media_next = '0;
            end
            default: ;
        endcase
    end

    always_comb begin
        result.is_paused   = paused_next;
        result.is_anchored = anchored_next;
        priority if (!anchored_next) begin
            result.media_clock = '0;
        end else if (mode_reg) begin
            result.media_clock = clk_at;
        end else if (paused_next) begin
            result.media_clock = pause_media_next;
        end else begin
            result.media_clock = (clk_at > max_media_next) ? max_media_next : clk_at;
        end
    end

    // ------------------------------------------------------------------
    // State and result registers
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            anchor_media_reg <= '0;
            anchor_sys_reg   <= '0;
            max_media_reg    <= '0;
            anchored_reg     <= 1'b0;
            paused_reg       <= 1'b0;
            pause_sys_reg    <= '0;
            pause_media_reg  <= '0;
        end else if (advance) begin
            anchor_media_reg <= anchor_media_next;
            anchor_sys_reg   <= anchor_sys_next;
            max_media_reg    <= max_media_next;
            anchored_reg     <= anchored_next;
            paused_reg       <= paused_next;
            pause_sys_reg    <= pause_sys_next;
            pause_media_reg  <= pause_media_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_reg <= result;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `MCAS_ASSERT_NOW(a_unanchored_zero, aclk, aresetn, m_valid && !m_data.is_anchored, m_data.media_clock == '0)
    `MCAS_ASSERT_NOW(a_stall_blocks_input, aclk, aresetn, in_valid_reg && out_valid_reg && !m_ready, !s_ready)
    `MCAS_ASSERT_NEXT(a_advance_fills_out, aclk, aresetn, advance, out_valid_reg)
    `MCAS_ASSERT_NEXT(a_resume_unpauses, aclk, aresetn, advance && (act == mcas_pkg::ACT_RESUME), !paused_reg)
    `MCAS_ASSERT_NEXT(a_clear_resets, aclk, aresetn, advance && (act == mcas_pkg::ACT_CLEAR), !anchored_reg && !paused_reg && (max_media_reg == '0))

endmodule
